@@ hw/rtl/ramt_pkg.sv @@
// Shared types and constants for the range-add / range-maximum tree.
`timescale 1ns / 1ps
package ramt_pkg;

  localparam int LEAVES_DEF     = 1024;
  localparam int VALUE_BITS_DEF = 32;
  localparam int POS_BITS       = 11;
  localparam int AMT_BITS       = 16;
  localparam int OUT_BITS       = 32;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VISIT,
    ST_COV,
    ST_PD0,
    ST_PD1,
    ST_PD2,
    ST_RET,
    ST_PU0,
    ST_PU1,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic load_cfg;
    logic clr_step;
    logic node_rd;
    logic cov_upd;
    logic pd0;
    logic pd1;
    logic pd2;
    logic ret_right;
    logic ret_pop;
    logic pu0;
    logic pu1;
    logic root_rd;
    logic res_acc;
    logic res_rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic disjoint;
    logic covered;
    logic clr_last;
    logic sp_zero;
    logic top_phase;
    logic is_query;
  } stat_t;

endpackage

@@ hw/rtl/ramt_ctrl.sv @@
// Sequencer for the tree walk, clearing pass and result handshake.
`timescale 1ns / 1ps
module ramt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  ramt_pkg::stat_t stat,
  output ramt_pkg::cmd_t  cmd
);

  ramt_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ramt_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    unique case (state_r)
      ramt_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = ramt_pkg::ST_IDLE;
      end
      ramt_pkg::ST_IDLE: begin
        cfg_ready = 1'b1;
        in_stall  = cfg_valid;
        if (cfg_valid) begin
          cmd.load_cfg = 1'b1;
          state_nxt    = ramt_pkg::ST_CLEAR;
        end else if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ramt_pkg::ST_VISIT;
        end
      end
      ramt_pkg::ST_VISIT: begin
        if (stat.disjoint) begin
          state_nxt = ramt_pkg::ST_RET;
        end else if (stat.covered) begin
          cmd.node_rd = 1'b1;
          state_nxt   = ramt_pkg::ST_COV;
        end else begin
          cmd.node_rd = 1'b1;
          state_nxt   = ramt_pkg::ST_PD0;
        end
      end
      ramt_pkg::ST_COV: begin
        cmd.cov_upd = 1'b1;
        state_nxt   = ramt_pkg::ST_RET;
      end
      ramt_pkg::ST_PD0: begin
        cmd.pd0   = 1'b1;
        state_nxt = ramt_pkg::ST_PD1;
      end
      ramt_pkg::ST_PD1: begin
        cmd.pd1   = 1'b1;
        state_nxt = ramt_pkg::ST_PD2;
      end
      ramt_pkg::ST_PD2: begin
        cmd.pd2   = 1'b1;
        state_nxt = ramt_pkg::ST_VISIT;
      end
      ramt_pkg::ST_RET: begin
        if (stat.sp_zero) begin
          if (stat.is_query) begin
            cmd.res_acc = 1'b1;
            state_nxt   = ramt_pkg::ST_OUT;
          end else begin
            cmd.root_rd = 1'b1;
            state_nxt   = ramt_pkg::ST_FIN;
          end
        end else if (!stat.top_phase) begin
          cmd.ret_right = 1'b1;
          state_nxt     = ramt_pkg::ST_VISIT;
        end else begin
          cmd.ret_pop = 1'b1;
          state_nxt   = stat.is_query ? ramt_pkg::ST_RET : ramt_pkg::ST_PU0;
        end
      end
      ramt_pkg::ST_PU0: begin
        cmd.pu0   = 1'b1;
        state_nxt = ramt_pkg::ST_PU1;
      end
      ramt_pkg::ST_PU1: begin
        cmd.pu1   = 1'b1;
        state_nxt = ramt_pkg::ST_RET;
      end
      ramt_pkg::ST_FIN: begin
        cmd.res_rd = 1'b1;
        state_nxt  = ramt_pkg::ST_OUT;
      end
      ramt_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ramt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ramt_pkg::ST_CLEAR;
    endcase
    out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);
  end

  assign out_valid = out_valid_r;

endmodule

@@ hw/rtl/ramt_dpath.sv @@
// Node memory, call stack, range compares and node arithmetic.
`timescale 1ns / 1ps
module ramt_dpath #(
  parameter int LEAVES     = ramt_pkg::LEAVES_DEF,
  parameter int VALUE_BITS = ramt_pkg::VALUE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  ramt_pkg::cmd_t                         cmd,
  output ramt_pkg::stat_t                        stat,
  input  logic                                   in_kind,
  input  logic [ramt_pkg::POS_BITS-1:0]          in_range_low,
  input  logic [ramt_pkg::POS_BITS-1:0]          in_range_high,
  input  logic signed [ramt_pkg::AMT_BITS-1:0]   in_add_amount,
  input  logic [ramt_pkg::POS_BITS-1:0]          cfg_used_leaves,
  output logic signed [ramt_pkg::OUT_BITS-1:0]   out_max_value
);

  localparam int PB    = ramt_pkg::POS_BITS;
  localparam int VB    = VALUE_BITS;
  localparam int NODES = 4 * LEAVES;
  localparam int NB    = $clog2(NODES);
  localparam int SD    = $clog2(LEAVES) + 2;
  localparam int SPB   = $clog2(SD + 1);
  localparam int SIB   = $clog2(SD);
  localparam logic [PB-1:0] USED_RST = PB'(LEAVES);

  logic [2*VB-1:0] mem [NODES];
  logic [2*VB-1:0] rdata_r;
  logic [NB-1:0]   rd_addr, wr_addr;
  logic [2*VB-1:0] wr_data;
  logic            wr_en;

  logic [PB-1:0]   used_r, ql_r, qr_r, cur_lo_r, cur_hi_r;
  logic            kind_r, found_r;
  logic [VB-1:0]   amt_r, acc_r, owed_r, lmax_r;
  logic [NB-1:0]   cur_node_r, clr_r;
  logic [SPB-1:0]  sp_r, sp_m1;
  logic [SIB-1:0]  top_idx;
  logic signed [ramt_pkg::OUT_BITS-1:0] res_r, out_r;

  logic [NB-1:0]   stk_node [SD];
  logic [PB-1:0]   stk_lo   [SD];
  logic [PB-1:0]   stk_hi   [SD];
  logic            stk_ph   [SD];

  logic [VB-1:0]   rmax, rpend, lmax_big;
  logic [NB-1:0]   top_node, cur_left, cur_right, top_left, top_right;
  logic [PB-1:0]   top_lo, top_hi, cur_mid, top_mid;
  logic [PB:0]     cur_sum, top_sum;
  logic [PB-1:0]   used_clamp;

  assign rmax      = rdata_r[VB-1:0];
  assign rpend     = rdata_r[2*VB-1:VB];
  assign sp_m1     = sp_r - 1'b1;
  assign top_idx   = sp_m1[SIB-1:0];
  assign top_node  = stk_node[top_idx];
  assign top_lo    = stk_lo[top_idx];
  assign top_hi    = stk_hi[top_idx];
  assign cur_left  = {cur_node_r[NB-2:0], 1'b0};
  assign cur_right = {cur_node_r[NB-2:0], 1'b1};
  assign top_left  = {top_node[NB-2:0], 1'b0};
  assign top_right = {top_node[NB-2:0], 1'b1};
  assign cur_sum   = {1'b0, cur_lo_r} + {1'b0, cur_hi_r};
  assign top_sum   = {1'b0, top_lo} + {1'b0, top_hi};
  assign cur_mid   = cur_sum[PB:1];
  assign top_mid   = top_sum[PB:1];
  assign lmax_big  = ($signed(lmax_r) > $signed(rmax)) ? lmax_r : rmax;

  always_comb begin
    if (cfg_used_leaves == '0) begin
      used_clamp = PB'(1);
    end else if (32'(cfg_used_leaves) > 32'(LEAVES)) begin
      used_clamp = USED_RST;
    end else begin
      used_clamp = cfg_used_leaves;
    end
  end

  assign stat.disjoint  = (qr_r < cur_lo_r) || (cur_hi_r < ql_r);
  assign stat.covered   = (ql_r <= cur_lo_r) && (cur_hi_r <= qr_r);
  assign stat.clr_last  = (clr_r == NB'(NODES - 1));
  assign stat.sp_zero   = (sp_r == '0);
  assign stat.top_phase = stk_ph[top_idx];
  assign stat.is_query  = (kind_r == ramt_pkg::KIND_QUERY);

  always_comb begin
    rd_addr = cur_node_r;
    if (cmd.node_rd) begin
      rd_addr = cur_node_r;
    end else if (cmd.pd0) begin
      rd_addr = cur_left;
    end else if (cmd.pd1) begin
      rd_addr = cur_right;
    end else if (cmd.ret_pop) begin
      rd_addr = top_left;
    end else if (cmd.pu0) begin
      rd_addr = cur_right;
    end else if (cmd.root_rd) begin
      rd_addr = NB'(1);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_node_r;
    wr_data = '0;
    if (cmd.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_r;
    end else if (cmd.cov_upd && !stat.is_query) begin
      wr_en   = 1'b1;
      wr_data = {rpend + amt_r, rmax + amt_r};
    end else if (cmd.pd0) begin
      wr_en   = 1'b1;
      wr_data = {{VB{1'b0}}, rmax};
    end else if (cmd.pd1) begin
      wr_en   = 1'b1;
      wr_addr = cur_left;
      wr_data = {rpend + owed_r, rmax + owed_r};
    end else if (cmd.pd2) begin
      wr_en   = 1'b1;
      wr_addr = cur_right;
      wr_data = {rpend + owed_r, rmax + owed_r};
    end else if (cmd.pu1) begin
      wr_en   = 1'b1;
      wr_data = {{VB{1'b0}}, lmax_big};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= USED_RST;
      clr_r  <= '0;
      sp_r   <= '0;
    end else begin
      if (cmd.load_cfg) begin
        used_r <= used_clamp;
        clr_r  <= '0;
      end
      if (cmd.clr_step) clr_r <= clr_r + 1'b1;
      if (cmd.load_item) sp_r <= '0;
      if (cmd.pd2) sp_r <= sp_r + 1'b1;
      if (cmd.ret_pop) sp_r <= sp_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_r     <= in_kind;
      ql_r       <= in_range_low;
      qr_r       <= in_range_high;
      amt_r      <= VB'(in_add_amount);
      cur_node_r <= NB'(1);
      cur_lo_r   <= PB'(1);
      cur_hi_r   <= used_r;
      acc_r      <= '0;
      found_r    <= 1'b0;
    end
    if (cmd.cov_upd && stat.is_query) begin
      if (!found_r || ($signed(rmax) > $signed(acc_r))) acc_r <= rmax;
      found_r <= 1'b1;
    end
    if (cmd.pd0) owed_r <= rpend;
    if (cmd.pd2) begin
      stk_node[sp_r[SIB-1:0]] <= cur_node_r;
      stk_lo[sp_r[SIB-1:0]]   <= cur_lo_r;
      stk_hi[sp_r[SIB-1:0]]   <= cur_hi_r;
      stk_ph[sp_r[SIB-1:0]]   <= 1'b0;
      cur_node_r <= cur_left;
      cur_hi_r   <= cur_mid;
    end
    if (cmd.ret_right) begin
      stk_ph[top_idx] <= 1'b1;
      cur_node_r      <= top_right;
      cur_lo_r        <= top_mid + 1'b1;
      cur_hi_r        <= top_hi;
    end
    if (cmd.ret_pop) cur_node_r <= top_node;
    if (cmd.pu0) lmax_r <= rmax;
    if (cmd.res_acc) res_r <= found_r ? ramt_pkg::OUT_BITS'($signed(acc_r)) : '0;
    if (cmd.res_rd) res_r <= ramt_pkg::OUT_BITS'($signed(rmax));
    if (cmd.out_load) out_r <= res_r;
  end

  assign out_max_value = out_r;

endmodule

@@ hw/rtl/range_add_range_max_tree_core.sv @@
// Top level of the range-add / range-maximum lazy segment tree.
//
//  channel | direction | handshake          | payload
//  in      | request   | in_valid/in_stall  | kind, range_low, range_high, add_amount
//  out     | result    | out_valid/out_stall| max_value
//  cfg     | write     | cfg_valid/cfg_ready| used_leaves
//
// One request at a time; each visited tree node is handled on the single read and
// single write port of the node memory.
// After reset and after every cfg write a clearing pass over all 4*LEAVES nodes runs;
// in_stall stays high during it.
// A waiting result sits in the output register while the next request is taken;
// out_stall delays the hand-over of a finished result, and no request is taken meanwhile.
`timescale 1ns / 1ps
module range_add_range_max_tree_core #(
  parameter int LEAVES     = ramt_pkg::LEAVES_DEF,
  parameter int VALUE_BITS = ramt_pkg::VALUE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_kind,
  input  logic [ramt_pkg::POS_BITS-1:0]        in_range_low,
  input  logic [ramt_pkg::POS_BITS-1:0]        in_range_high,
  input  logic signed [ramt_pkg::AMT_BITS-1:0] in_add_amount,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [ramt_pkg::OUT_BITS-1:0] out_max_value,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ramt_pkg::POS_BITS-1:0]        cfg_used_leaves
);

  ramt_pkg::cmd_t  cmd;
  ramt_pkg::stat_t stat;

  ramt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ramt_dpath #(
    .LEAVES     (LEAVES),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (in_kind),
    .in_range_low    (in_range_low),
    .in_range_high   (in_range_high),
    .in_add_amount   (in_add_amount),
    .cfg_used_leaves (cfg_used_leaves),
    .out_max_value   (out_max_value)
  );

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while walk in progress");

  a_clear_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> (in_stall && !cfg_ready))
    else $error("clearing pass not started after cfg write");

  a_clear_after_rst: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("clearing pass not started after reset");

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result overwritten while held");

endmodule

@@ tb/tb_range_add_range_max_tree_core.sv @@
// Testbench for the range-add / range-maximum tree core, checked against its own lazy tree.
`timescale 1ns / 1ps
class max_tree_board;
  localparam int NODES = 4 * ramt_pkg::LEAVES_DEF;
  logic signed [31:0] node_peak[NODES];
  logic signed [31:0] node_owed[NODES];
  int span;
  logic signed [31:0] peaks_due[$];
  int fails;

  function new();
    fails = 0;
    set_span(ramt_pkg::LEAVES_DEF);
  endfunction

  function void set_span(int value);
    span = (value < 1) ? 1 : (value > ramt_pkg::LEAVES_DEF) ? ramt_pkg::LEAVES_DEF : value;
    foreach (node_peak[i]) begin
      node_peak[i] = '0;
      node_owed[i] = '0;
    end
  endfunction

  function void push_owed(int node, int lo, int hi);
    int a;
    int b;
    a = 2 * node;
    b = 2 * node + 1;
    if (lo == hi || b >= NODES) return;
    node_peak[a] += node_owed[node];
    node_peak[b] += node_owed[node];
    node_owed[a] += node_owed[node];
    node_owed[b] += node_owed[node];
    node_owed[node] = '0;
  endfunction

  function void add_span(int node, int lo, int hi, int ql, int qr, logic signed [31:0] amt);
    int mid;
    if (node >= NODES || qr < lo || hi < ql) return;
    if (ql <= lo && hi <= qr) begin
      node_owed[node] += amt;
      node_peak[node] += amt;
      return;
    end
    push_owed(node, lo, hi);
    mid = (lo + hi) / 2;
    add_span(2 * node, lo, mid, ql, qr, amt);
    add_span(2 * node + 1, mid + 1, hi, ql, qr, amt);
    if (2 * node + 1 < NODES) begin
      node_peak[node] = (node_peak[2 * node] > node_peak[2 * node + 1]) ?
                        node_peak[2 * node] : node_peak[2 * node + 1];
    end
  endfunction

  function void peak_of(int node, int lo, int hi, int ql, int qr,
                        output bit found, output logic signed [31:0] peak);
    int mid;
    bit fa;
    bit fb;
    logic signed [31:0] pa;
    logic signed [31:0] pb;
    found = 0;
    peak = '0;
    if (node >= NODES || qr < lo || hi < ql) return;
    if (ql <= lo && hi <= qr) begin
      found = 1;
      peak = node_peak[node];
      return;
    end
    push_owed(node, lo, hi);
    mid = (lo + hi) / 2;
    peak_of(2 * node, lo, mid, ql, qr, fa, pa);
    peak_of(2 * node + 1, mid + 1, hi, ql, qr, fb, pb);
    found = fa || fb;
    if (fa && fb) peak = (pa > pb) ? pa : pb;
    else peak = fa ? pa : pb;
  endfunction

  function void note_request(logic kind, int ql, int qr, logic signed [15:0] amt);
    bit found;
    logic signed [31:0] peak;
    if (kind == ramt_pkg::KIND_ADD) begin
      add_span(1, 1, span, ql, qr, 32'(amt));
      peak = node_peak[1];
    end else begin
      peak_of(1, 1, span, ql, qr, found, peak);
      if (!found) peak = '0;
    end
    peaks_due = {peaks_due, peak};
  endfunction

  function void check_result(logic signed [31:0] got);
    logic signed [31:0] want;
    if (peaks_due.size() == 0) begin
      $error("max_value: no result expected, got %0d", got);
      fails++;
      return;
    end
    want = peaks_due.pop_front();
    if (got !== want) begin
      $error("max_value: expected %0d, got %0d", want, got);
      fails++;
    end
  endfunction
endclass

module tb_range_add_range_max_tree_core;

  localparam int WATCH_LIMIT = 60000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = 1'b0;
  logic [ramt_pkg::POS_BITS-1:0] in_range_low = '0;
  logic [ramt_pkg::POS_BITS-1:0] in_range_high = '0;
  logic signed [ramt_pkg::AMT_BITS-1:0] in_add_amount = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ramt_pkg::OUT_BITS-1:0] out_max_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ramt_pkg::POS_BITS-1:0] cfg_used_leaves = '0;

  max_tree_board board = new();
  int stall_left = 0;
  bit sink_calm = 0;
  bit send_calm = 0;
  int quiet_cycles = 0;

  range_add_range_max_tree_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_range_low(in_range_low), .in_range_high(in_range_high),
    .in_add_amount(in_add_amount),
    .out_valid(out_valid), .out_stall(out_stall), .out_max_value(out_max_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_used_leaves(cfg_used_leaves)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      quiet_cycles = quiet_cycles + 1;
      if (out_valid && !out_stall) begin
        board.check_result(out_max_value);
        stall_left = sink_calm ? 0 : $urandom_range(0, 9);
        quiet_cycles = 0;
      end
      if (in_valid && !in_stall) begin
        board.note_request(in_kind, in_range_low, in_range_high, in_add_amount);
        quiet_cycles = 0;
      end
      if (cfg_valid && cfg_ready) begin
        board.set_span(cfg_used_leaves);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("tb_range_add_range_max_tree_core failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_request(logic kind, int lo, int hi, logic signed [15:0] amt);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_range_low <= lo[ramt_pkg::POS_BITS-1:0];
    in_range_high <= hi[ramt_pkg::POS_BITS-1:0];
    in_add_amount <= amt;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.peaks_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_span(int value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_used_leaves <= value[ramt_pkg::POS_BITS-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_requests(int count);
    int lo;
    int hi;
    int top;
    top = board.span;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 85) begin
        lo = $urandom_range(1, top);
        hi = $urandom_range(lo - 1, top);
      end else begin
        lo = $urandom_range(0, 2047);
        hi = $urandom_range(0, 2047);
      end
      send_request($urandom_range(0, 1), lo, hi, 16'($urandom));
    end
  endtask

  initial begin
    int spans[10] = '{1, 2, 3, 7, 1024, 333, 0, 2047, 64, 1000};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_request(ramt_pkg::KIND_QUERY, 1, 1024, 16'sd0);
    send_request(ramt_pkg::KIND_ADD, 1, 1024, 16'sd32767);
    send_request(ramt_pkg::KIND_ADD, 1, 1, -16'sd32768);
    send_request(ramt_pkg::KIND_QUERY, 1, 1, 16'sd5);
    send_request(ramt_pkg::KIND_QUERY, 2, 1024, -16'sd1);
    send_request(ramt_pkg::KIND_QUERY, 5, 4, 16'sd0);
    send_request(ramt_pkg::KIND_QUERY, 0, 0, 16'sd0);
    send_request(ramt_pkg::KIND_QUERY, 1025, 2047, 16'sd0);
    send_request(ramt_pkg::KIND_ADD, 10, 3, 16'sd1234);
    send_request(ramt_pkg::KIND_ADD, 0, 2047, -16'sd7);
    send_request(ramt_pkg::KIND_ADD, 300, 700, -16'sd1);
    send_request(ramt_pkg::KIND_QUERY, 299, 701, 16'sd0);
    send_request(ramt_pkg::KIND_QUERY, 512, 513, 16'sd0);
    send_request(ramt_pkg::KIND_ADD, 1024, 1024, 16'sd32767);
    send_request(ramt_pkg::KIND_QUERY, 1000, 2047, -16'sd32768);
    send_request(ramt_pkg::KIND_ADD, 1025, 2047, 16'sd100);
    send_request(ramt_pkg::KIND_QUERY, 1024, 1024, 16'sd0);
    send_request(ramt_pkg::KIND_QUERY, 1, 2047, 16'sd0);

    random_requests(130);
    foreach (spans[i]) begin
      write_span(spans[i]);
      sink_calm = (i % 4 == 1);
      send_calm = (i % 4 == 2);
      random_requests(130);
    end

    in_valid <= 1'b0;
    while (board.peaks_due.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (board.fails == 0) begin
      $display("tb_range_add_range_max_tree_core passed");
    end else begin
      $display("tb_range_add_range_max_tree_core failed");
    end
    $finish;
  end
endmodule
